[rtl/tksd_pkg.sv]
// Shared constants for the terminal key sequence decoder: stream widths, codes and key bytes.
package tksd_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int CMD_W       = 5;
    localparam int ARG_W       = 16;

    typedef logic [7:0]       t_byte;
    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [ARG_W-1:0] t_arg;

    // parser modes
    localparam logic [2:0] MODE_START   = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_CSI     = 3'd2;
    localparam logic [2:0] MODE_CAN     = 3'd3;
    localparam logic [2:0] MODE_STR     = 3'd4;
    localparam logic [2:0] MODE_CHARSET = 3'd5;
    localparam logic [2:0] MODE_SKIP    = 3'd6;

    // editing commands
    localparam t_cmd CMD_ABORT      = 5'd0;
    localparam t_cmd CMD_ENTER      = 5'd1;
    localparam t_cmd CMD_INSERT     = 5'd2;
    localparam t_cmd CMD_BACKSPACE  = 5'd3;
    localparam t_cmd CMD_DELETE     = 5'd4;
    localparam t_cmd CMD_UP         = 5'd5;
    localparam t_cmd CMD_DOWN       = 5'd6;
    localparam t_cmd CMD_RIGHT      = 5'd7;
    localparam t_cmd CMD_LEFT       = 5'd8;
    localparam t_cmd CMD_END        = 5'd9;
    localparam t_cmd CMD_HOME       = 5'd10;
    localparam t_cmd CMD_WORDRIGHT  = 5'd11;
    localparam t_cmd CMD_WORDLEFT   = 5'd12;
    localparam t_cmd CMD_ERASE_EOL  = 5'd13;
    localparam t_cmd CMD_ERASE_BOL  = 5'd14;
    localparam t_cmd CMD_ERASE_LINE = 5'd15;
    localparam t_cmd CMD_ERASE_WORD = 5'd16;
    localparam t_cmd CMD_CLEAR      = 5'd17;
    localparam t_cmd CMD_UNMAPPED   = 5'd18;
    localparam t_cmd CMD_BEEP       = 5'd19;

    // key bytes
    localparam t_byte KEY_ETX   = 8'h03;
    localparam t_byte KEY_EOT   = 8'h04;
    localparam t_byte KEY_BEL   = 8'h07;
    localparam t_byte KEY_LF    = 8'h0A;
    localparam t_byte KEY_VT    = 8'h0B;
    localparam t_byte KEY_FF    = 8'h0C;
    localparam t_byte KEY_CR    = 8'h0D;
    localparam t_byte KEY_NAK   = 8'h15;
    localparam t_byte KEY_ETB   = 8'h17;
    localparam t_byte KEY_CAN   = 8'h18;
    localparam t_byte KEY_ESC   = 8'h1B;
    localparam t_byte KEY_SPACE = 8'h20;
    localparam t_byte KEY_STAR  = 8'h2A;
    localparam t_byte KEY_PLUS  = 8'h2B;
    localparam t_byte KEY_ZERO  = 8'h30;
    localparam t_byte KEY_NINE  = 8'h39;
    localparam t_byte KEY_SEMI  = 8'h3B;
    localparam t_byte KEY_QUEST = 8'h3F;
    localparam t_byte KEY_A     = 8'h41;
    localparam t_byte KEY_B     = 8'h42;
    localparam t_byte KEY_C     = 8'h43;
    localparam t_byte KEY_D     = 8'h44;
    localparam t_byte KEY_F     = 8'h46;
    localparam t_byte KEY_H     = 8'h48;
    localparam t_byte KEY_J     = 8'h4A;
    localparam t_byte KEY_K     = 8'h4B;
    localparam t_byte KEY_Y     = 8'h59;
    localparam t_byte KEY_LBRK  = 8'h5B;
    localparam t_byte KEY_UNDER = 8'h5F;
    localparam t_byte KEY_TILDE = 8'h7E;
    localparam t_byte KEY_DEL   = 8'h7F;
    localparam t_byte KEY_ST    = 8'h9C;

    // argument values that select variants, and the clamp for accumulated arguments
    localparam t_arg ARG_MOD_CTRL = 16'd5;
    localparam t_arg ARG_HOME     = 16'd1;
    localparam t_arg ARG_DELETE   = 16'd3;
    localparam t_arg ARG_END      = 16'd4;
    localparam t_arg ARG_MAX      = 16'hFFFF;

endpackage

[rtl/terminal_key_sequence_decoder.sv]
// Terminal key sequence decoder: keyboard bytes in, line-editing commands out.
//
// One request is taken every cycle as long as results drain; a request is captured in the input
// register, is decoded against the parser state in a single pass and lands in the result
// register. Bytes that only advance an escape sequence produce no result. Only the first two
// CSI arguments are kept, since no final byte looks further; MAX_CSI_ARGS sets where further
// ';' separators stop counting.
module terminal_key_sequence_decoder #(
    parameter int MAX_CSI_ARGS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] key_byte, [8] line_empty, [15:9] zero
    input  logic [tksd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [4:0] command_code, [12:5] key_char, [15:13] zero
    output logic [tksd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tksd_pkg::*;

    localparam int CNT_W = $clog2(MAX_CSI_ARGS + 2);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_CSI_ARGS);
    localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_CSI_ARGS + 1);

    // input register
    logic        r_in_valid;
    t_byte       r_in_byte;
    logic        r_in_empty;

    // parser state
    logic [2:0]       r_mode, n_mode;
    t_arg             r_arg0, n_arg0;
    t_arg             r_arg1, n_arg1;
    logic [CNT_W-1:0] r_arg_cnt, n_arg_cnt;
    logic             r_prefix, n_prefix;
    logic [1:0]       r_skip, n_skip;

    // result register
    logic  r_out_valid;
    t_cmd  r_out_cmd;
    t_byte r_out_char;

    logic  w_adv;
    logic  w_res_valid;
    t_cmd  w_cmd;
    t_byte w_char;
    t_arg  w_acc_src;
    logic [ARG_W+3:0] w_acc;
    t_arg  w_acc_sat;
    t_arg  w_second;
    logic  w_is_digit;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_char, r_out_cmd};

    // decimal accumulate: arg * 10 + digit, clamped
    assign w_is_digit = (r_in_byte >= KEY_ZERO) && (r_in_byte <= KEY_NINE);
    assign w_acc_src  = (r_arg_cnt == CNT_TWO) ? r_arg1 : r_arg0;
    assign w_acc      = ({4'b0000, w_acc_src} << 3) + ({4'b0000, w_acc_src} << 1)
                        + (ARG_W+4)'(r_in_byte - KEY_ZERO);
    assign w_acc_sat  = (w_acc > (ARG_W+4)'(ARG_MAX)) ? ARG_MAX : w_acc[ARG_W-1:0];
    assign w_second   = (r_arg_cnt >= CNT_TWO) ? r_arg1 : '0;

    always_comb begin
        n_mode      = r_mode;
        n_arg0      = r_arg0;
        n_arg1      = r_arg1;
        n_arg_cnt   = r_arg_cnt;
        n_prefix    = r_prefix;
        n_skip      = r_skip;
        w_res_valid = 1'b0;
        w_cmd       = CMD_ABORT;
        w_char      = '0;

        case (r_mode)
            MODE_ESC: begin
                if (r_in_byte == KEY_LBRK) begin
                    n_mode    = MODE_CSI;
                    n_arg0    = '0;
                    n_arg1    = '0;
                    n_arg_cnt = CNT_ONE;
                    n_prefix  = 1'b0;
                end else if (r_in_byte == KEY_UNDER) begin
                    n_mode = MODE_STR;
                end else if (r_in_byte == KEY_STAR || r_in_byte == KEY_PLUS
                             || r_in_byte == KEY_SPACE) begin
                    n_mode = MODE_CHARSET;
                end else begin
                    n_mode = MODE_START;
                end
            end
            MODE_CSI: begin
                if (w_is_digit) begin
                    if (r_arg_cnt == CNT_ONE) begin
                        n_arg0 = w_acc_sat;
                    end else if (r_arg_cnt == CNT_TWO) begin
                        n_arg1 = w_acc_sat;
                    end
                end else if (r_in_byte == KEY_SEMI) begin
                    if (r_arg_cnt < CNT_MAX) begin
                        if (r_arg_cnt == CNT_ONE) begin
                            n_arg1 = '0;
                        end
                        n_arg_cnt = r_arg_cnt + CNT_ONE;
                    end else begin
                        n_arg_cnt = CNT_OVER;
                    end
                end else if (r_in_byte == KEY_SPACE || r_in_byte == KEY_QUEST) begin
                    n_prefix = 1'b1;
                end else begin
                    n_mode = MODE_START;
                    // final bytes; anything outside '0'..'~', or any final after a prefix, aborts silently
                    if (!r_prefix && r_in_byte >= KEY_ZERO && r_in_byte <= KEY_TILDE) begin
                        case (r_in_byte)
                            KEY_A: begin
                                w_res_valid = 1'b1;
                                w_cmd       = CMD_UP;
                            end
                            KEY_B: begin
                                w_res_valid = 1'b1;
                                w_cmd       = CMD_DOWN;
                            end
                            KEY_C: begin
                                w_res_valid = 1'b1;
                                w_cmd = (w_second == ARG_MOD_CTRL) ? CMD_WORDRIGHT : CMD_RIGHT;
                            end
                            KEY_D: begin
                                w_res_valid = 1'b1;
                                w_cmd = (w_second == ARG_MOD_CTRL) ? CMD_WORDLEFT : CMD_LEFT;
                            end
                            KEY_F: begin
                                w_res_valid = 1'b1;
                                w_cmd       = CMD_END;
                            end
                            KEY_H: begin
                                w_res_valid = 1'b1;
                                w_cmd       = CMD_HOME;
                            end
                            KEY_J: begin
                                w_res_valid = 1'b1;
                                w_cmd       = CMD_ERASE_EOL;
                            end
                            KEY_K: begin
                                w_res_valid = 1'b1;
                                w_cmd       = CMD_ERASE_BOL;
                            end
                            KEY_Y: begin
                                n_mode = MODE_SKIP;
                                n_skip = 2'd2;
                            end
                            KEY_TILDE: begin
                                if (r_arg0 == ARG_HOME) begin
                                    w_res_valid = 1'b1;
                                    w_cmd       = CMD_HOME;
                                end else if (r_arg0 == ARG_DELETE) begin
                                    w_res_valid = 1'b1;
                                    w_cmd       = CMD_DELETE;
                                end else if (r_arg0 == ARG_END) begin
                                    w_res_valid = 1'b1;
                                    w_cmd       = CMD_END;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            MODE_CAN: begin
                n_mode = MODE_START;
                if (r_in_byte == KEY_DEL) begin
                    w_res_valid = 1'b1;
                    w_cmd       = CMD_ERASE_BOL;
                end
            end
            MODE_STR: begin
                if (r_in_byte == KEY_ST || r_in_byte == KEY_BEL) begin
                    n_mode = MODE_START;
                end
            end
            MODE_CHARSET: begin
                n_mode = MODE_START;
            end
            MODE_SKIP: begin
                if (r_skip > 2'd1) begin
                    n_skip = r_skip - 2'd1;
                end else begin
                    n_skip = 2'd0;
                    n_mode = MODE_START;
                end
            end
            default: begin
                n_mode      = MODE_START;
                w_res_valid = 1'b1;
                case (r_in_byte)
                    KEY_ETX: w_cmd = CMD_ABORT;
                    KEY_EOT: w_cmd = r_in_empty ? CMD_ABORT : CMD_BEEP;
                    KEY_CR, KEY_LF: w_cmd = CMD_ENTER;
                    KEY_BEL: w_cmd = CMD_BEEP;
                    KEY_FF:  w_cmd = CMD_CLEAR;
                    KEY_DEL: w_cmd = CMD_BACKSPACE;
                    KEY_VT:  w_cmd = CMD_ERASE_EOL;
                    KEY_NAK: w_cmd = CMD_ERASE_LINE;
                    KEY_ETB: w_cmd = CMD_ERASE_WORD;
                    KEY_ESC: begin
                        n_mode      = MODE_ESC;
                        w_res_valid = 1'b0;
                    end
                    KEY_CAN: begin
                        n_mode      = MODE_CAN;
                        w_res_valid = 1'b0;
                    end
                    default: begin
                        w_char = r_in_byte;
                        w_cmd  = (r_in_byte >= KEY_SPACE && r_in_byte <= KEY_TILDE)
                                 ? CMD_INSERT : CMD_UNMAPPED;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata[7:0];
            r_in_empty <= s_axis_tdata[8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_START;
            r_arg0    <= '0;
            r_arg1    <= '0;
            r_arg_cnt <= CNT_ONE;
            r_prefix  <= 1'b0;
            r_skip    <= 2'd0;
        end else if (w_adv) begin
            r_mode    <= n_mode;
            r_arg0    <= n_arg0;
            r_arg1    <= n_arg1;
            r_arg_cnt <= n_arg_cnt;
            r_prefix  <= n_prefix;
            r_skip    <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_valid) begin
            r_out_cmd  <= w_cmd;
            r_out_char <= w_char;
        end
    end

endmodule

[rtl/tksd_checker.sv]
// Port-level checks for the terminal key sequence decoder, bound to the top level.
module tksd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tksd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tksd_pkg::*;

    // no result may be pending right after reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_char_only_for_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4:0] != CMD_INSERT && m_axis_tdata[4:0] != CMD_UNMAPPED
        |-> m_axis_tdata[12:5] == 8'h00 && m_axis_tdata[15:13] == 3'b000)
        else $error("character on a non-key command");

    a_insert_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4:0] == CMD_INSERT
        |-> m_axis_tdata[12:5] >= KEY_SPACE && m_axis_tdata[12:5] <= KEY_TILDE)
        else $error("insert of a non-printable byte");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:0] <= CMD_BEEP)
        else $error("command code out of range");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
